>>> src/lpfd_pkg.sv
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned CODE_OFFSET = 4;
  localparam int unsigned LEN_OFFSET  = 6;

  localparam int unsigned POS_W = 16;
  localparam int unsigned MAX_W = 17;

  localparam logic [1:0] RK_HEADER  = 2'd0;
  localparam logic [1:0] RK_PAYLOAD = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;

  localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 17'd65543;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] stream_id;
    logic [7:0]  request_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

>>> src/lpfd_parser.sv
`timescale 1ns / 1ps

module lpfd_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     kind,
  input  logic [7:0]               data_byte,
  input  logic [lpfd_pkg::MAX_W-1:0] max_frame_bytes,
  output logic                     res_valid,
  output lpfd_pkg::result_t        res
);

  lpfd_pkg::phase_t               phase_r, phase_nxt;
  logic [lpfd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [31:0]                    sid_r, sid_nxt;
  logic [7:0]                     code_r, code_nxt;
  logic [15:0]                    len_r, len_nxt;
  logic [lpfd_pkg::POS_W-1:0]     pos_inc;
  logic [lpfd_pkg::MAX_W-1:0]     frame_size;
  logic [1:0]                     rk;
  logic [7:0]                     pbyte;
  logic                           last;

  assign pos_inc = pos_r + lpfd_pkg::POS_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sid_nxt    = sid_r;
    code_nxt   = code_r;
    len_nxt    = len_r;
    res_valid  = 1'b0;
    rk         = lpfd_pkg::RK_HEADER;
    pbyte      = 8'd0;
    last       = 1'b0;
    frame_size = '0;
    if (kind) begin
      phase_nxt = lpfd_pkg::PH_HEADER;
      pos_nxt   = '0;
    end else begin
      case (phase_r)
        lpfd_pkg::PH_HEADER: begin
          if (pos_r < lpfd_pkg::POS_W'(lpfd_pkg::CODE_OFFSET)) begin
            sid_nxt = {sid_r[23:0], data_byte};
          end else if (pos_r == lpfd_pkg::POS_W'(lpfd_pkg::CODE_OFFSET)) begin
            code_nxt = data_byte;
          end else if (pos_r >= lpfd_pkg::POS_W'(lpfd_pkg::LEN_OFFSET)) begin
            len_nxt = {len_r[7:0], data_byte};
          end
          frame_size = lpfd_pkg::MAX_W'(lpfd_pkg::HDR_BYTES) + lpfd_pkg::MAX_W'(len_nxt);
          if (pos_r < lpfd_pkg::POS_W'(lpfd_pkg::HDR_BYTES - 1)) begin
            pos_nxt = pos_inc;
          end else begin
            pos_nxt   = '0;
            res_valid = 1'b1;
            if (frame_size > max_frame_bytes) begin
              phase_nxt = lpfd_pkg::PH_ERROR;
              rk        = lpfd_pkg::RK_ERROR;
            end else if (len_nxt == 16'd0) begin
              phase_nxt = lpfd_pkg::PH_HEADER;
              last      = 1'b1;
            end else begin
              phase_nxt = lpfd_pkg::PH_PAYLOAD;
            end
          end
        end
        lpfd_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          rk        = lpfd_pkg::RK_PAYLOAD;
          pbyte     = data_byte;
          if (pos_inc >= len_r) begin
            phase_nxt = lpfd_pkg::PH_HEADER;
            pos_nxt   = '0;
            last      = 1'b1;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.result_kind    = rk;
    res.stream_id      = sid_nxt;
    res.request_code   = code_nxt;
    res.payload_length = len_nxt;
    res.payload_byte   = pbyte;
    res.last           = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpfd_pkg::PH_HEADER;
      pos_r   <= '0;
      sid_r   <= '0;
      code_r  <= '0;
      len_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sid_r   <= sid_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

>>> src/length_prefixed_frame_deframer_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                                   | Transfer when
// in       | in_kind, in_data_byte                   | in_valid & in_ready
// out      | out_result_kind .. out_last             | out_valid & out_ready
// cfg      | cfg_wr_data (max_frame_bytes)           | cfg_wr_en
//
// One input transfer per cycle while the output is not stalled; a result appears in the
// cycle after the byte that causes it, from a single output register.
// in_ready is high while the output register is empty or being drained.
// Synchronous active-low reset returns to the header phase, max frame 65543.
// A stalled output holds its result and blocks further input.

module length_prefixed_frame_deframer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_result_kind,
  output logic [31:0]                out_stream_id,
  output logic [7:0]                 out_request_code,
  output logic [15:0]                out_payload_length,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [lpfd_pkg::MAX_W-1:0] cfg_wr_data
);

  logic [lpfd_pkg::MAX_W-1:0] max_frame_r;
  logic                       out_valid_r, out_valid_nxt;
  lpfd_pkg::result_t          out_r;
  lpfd_pkg::result_t          res;
  logic                       res_valid;
  logic                       step;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  lpfd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .kind            (in_kind),
    .data_byte       (in_data_byte),
    .max_frame_bytes (max_frame_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= lpfd_pkg::MAX_FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_frame_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_r.result_kind;
  assign out_stream_id      = out_r.stream_id;
  assign out_request_code   = out_r.request_code;
  assign out_payload_length = out_r.payload_length;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_last           = out_r.last;

endmodule

>>> src/lpfd_checker.sv
`timescale 1ns / 1ps

module lpfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_result_kind,
  input logic [15:0]                out_payload_length,
  input logic [7:0]                 out_payload_byte,
  input logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind && !(out_valid && !out_ready) |=> !out_valid)
    else $error("restart produced a result");

  a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == lpfd_pkg::RK_ERROR |-> !out_last)
    else $error("error result flagged last");

  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == lpfd_pkg::RK_HEADER
      |-> out_last == (out_payload_length == 16'd0))
    else $error("header last flag disagrees with length");

  a_pbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != lpfd_pkg::RK_PAYLOAD |-> out_payload_byte == 8'd0)
    else $error("payload byte set on non-payload result");

endmodule

bind length_prefixed_frame_deframer_core lpfd_checker u_lpfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_kind            (in_kind),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_payload_length (out_payload_length),
  .out_payload_byte   (out_payload_byte),
  .out_last           (out_last)
);
